### hdl/hex_address_normalizer_core_macros.svh
// Assertion macros shared by the verification collateral of the address normalizer.
// No dependencies; included by the checker module.
`ifndef HEX_ADDRESS_NORMALIZER_CORE_MACROS_SVH
`define HEX_ADDRESS_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HXN_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HXN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hxn_pkg.sv
// Shared types, constants and character classes for the hex address normalizer.
// No dependencies; imported by every module of the block.
package hxn_pkg;

    // Largest output length the block will ever report.
    localparam int LENGTH_MAX = 255;

    // Up to three results per input beat: separator, digit, summary.
    localparam int PUSH_MAX = 3;
    localparam int PUSH_CW  = $clog2(PUSH_MAX + 1);

    // Result queue sizing.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_DELIM_A  = 3'd0,
        REG_DELIM_B  = 3'd1,
        REG_DELIM_C  = 3'd2,
        REG_DELIM_D  = 3'd3,
        REG_OUT_SEP  = 3'd4,
        REG_OUT_LIM  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_DOUBLE_DELIM = 2'd1,
        ST_BAD_DIGIT    = 2'd2,
        ST_OPEN_PAIR    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_CHAR    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_char;
        logic [1:0] status;
        logic [7:0] length;
        logic       run_end;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] delim_a;
        logic [7:0] delim_b;
        logic [7:0] delim_c;
        logic [7:0] delim_d;
        logic [7:0] out_separator;
        logic [7:0] out_limit;
    } cfg_t;

    // Results produced by one processed input beat, in order.
    typedef struct packed {
        logic [PUSH_CW-1:0]             n;
        out_beat_t [PUSH_MAX-1:0]       beats;
    } hxn_push_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic out_beat_t char_beat(input logic [7:0] c);
        out_beat_t b;
        b          = '0;
        b.kind     = KIND_CHAR;
        b.out_char = c;
        return b;
    endfunction

endpackage

### hdl/hex_address_normalizer_core.sv
// Hex address normalizer: takes one character per input beat, skips whitespace and
// configured delimiters, copies hex digits in pairs with the output separator between
// pairs, and closes each string with a summary beat (status, length; length 0 on error).
// A beat with at most one result is taken every cycle while m_ready is high; a beat
// with more results holds off input until the one-beat-per-cycle output port drains
// the four-entry queue. Results pass the input register, then the queue. Configuration
// registers at byte addresses 0x00..0x14 must be written only while idle (unchecked).
module hex_address_normalizer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  hxn_pkg::in_beat_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output hxn_pkg::out_beat_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hxn_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import hxn_pkg::*;

    cfg_t      cfg;
    hxn_push_t push;
    logic      room;

    hxn_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hxn_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg),
        .room    (room),
        .push    (push)
    );

    hxn_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### hdl/hxn_regs.sv
// Configuration register file with an APB-style access port.
// Depends on hxn_pkg for the register map and the configuration struct.
module hxn_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hxn_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output hxn_pkg::cfg_t               cfg
);
    import hxn_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;
    logic [7:0] rd_byte;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_DELIM_A: cfg_next.delim_a       = pwdata[7:0];
                REG_DELIM_B: cfg_next.delim_b       = pwdata[7:0];
                REG_DELIM_C: cfg_next.delim_c       = pwdata[7:0];
                REG_DELIM_D: cfg_next.delim_d       = pwdata[7:0];
                REG_OUT_SEP: cfg_next.out_separator = pwdata[7:0];
                REG_OUT_LIM: cfg_next.out_limit     = pwdata[7:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DELIM_A: rd_byte = cfg_reg.delim_a;
            REG_DELIM_B: rd_byte = cfg_reg.delim_b;
            REG_DELIM_C: rd_byte = cfg_reg.delim_c;
            REG_DELIM_D: rd_byte = cfg_reg.delim_d;
            REG_OUT_SEP: rd_byte = cfg_reg.out_separator;
            REG_OUT_LIM: rd_byte = cfg_reg.out_limit;
            default:     rd_byte = 8'h00;
        endcase
    end

    assign prdata = {24'h0, rd_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delim_a       <= 8'd58;
            cfg_reg.delim_b       <= 8'd45;
            cfg_reg.delim_c       <= 8'd0;
            cfg_reg.delim_d       <= 8'd0;
            cfg_reg.out_separator <= 8'd58;
            cfg_reg.out_limit     <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/hxn_parser.sv
// Input register and per-character parsing logic of the address normalizer.
// Depends on hxn_pkg for payload types, status codes and character classes.
module hxn_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hxn_pkg::in_beat_t   s_data,
    input  hxn_pkg::cfg_t       cfg,
    input  logic                room,
    output hxn_pkg::hxn_push_t  push
);
    import hxn_pkg::*;

    logic       in_vld_reg;
    logic       in_vld_next;
    in_beat_t   in_reg;
    logic       fire;

    logic       ph_reg, ph_next;
    logic       ad_reg, ad_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       halt_reg, halt_next;
    status_t    err_reg, err_next;

    logic [7:0] lim;
    logic [7:0] c;
    logic       delim_hit;
    hxn_push_t  res;

    // The queue must have room for the worst case before a beat is processed.
    assign fire        = in_vld_reg && room;
    assign s_ready     = !in_vld_reg || fire;
    assign in_vld_next = s_valid ? 1'b1 : (in_vld_reg && !fire);

    assign lim = (cfg.out_limit < LENGTH_MAX) ? cfg.out_limit : 8'(LENGTH_MAX);
    assign c   = in_reg.in_char;
    assign delim_hit = (c != 8'h00) && (c == cfg.delim_a || c == cfg.delim_b ||
                                       c == cfg.delim_c || c == cfg.delim_d);

    always_comb begin
        ph_next   = ph_reg;
        ad_next   = ad_reg;
        cnt_next  = cnt_reg;
        halt_next = halt_reg;
        err_next  = err_reg;
        res       = '0;

        if (!halt_next && cnt_next >= lim) begin
            halt_next = 1'b1;
        end

        if (!halt_next) begin
            if (c == 8'h00) begin
                if (ph_next) begin
                    err_next = ST_OPEN_PAIR;
                end
                halt_next = 1'b1;
            end else if (ph_next) begin
                if (!is_hex(c)) begin
                    err_next  = ST_BAD_DIGIT;
                    halt_next = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    ad_next = 1'b0;
                    res.beats[res.n] = char_beat(c);
                    res.n    = res.n + 1'b1;
                    cnt_next = cnt_next + 8'd1;
                    if (cnt_next >= lim) begin
                        halt_next = 1'b1;
                    end
                end
            end else if (is_ws(c)) begin
                ph_next = ph_reg;
            end else if (delim_hit) begin
                if (ad_next) begin
                    err_next  = ST_DOUBLE_DELIM;
                    halt_next = 1'b1;
                end else begin
                    ad_next = 1'b1;
                end
            end else begin
                // A new pair: the separator goes first unless this is the first pair or the separator is 0x00.
                if (cnt_next != 8'd0 && cfg.out_separator != 8'h00) begin
                    res.beats[res.n] = char_beat(cfg.out_separator);
                    res.n    = res.n + 1'b1;
                    cnt_next = cnt_next + 8'd1;
                    if (cnt_next >= lim) begin
                        halt_next = 1'b1;
                    end
                end
                if (!halt_next) begin
                    if (!is_hex(c)) begin
                        err_next  = ST_BAD_DIGIT;
                        halt_next = 1'b1;
                    end else begin
                        ph_next = 1'b1;
                        res.beats[res.n] = char_beat(c);
                        res.n    = res.n + 1'b1;
                        cnt_next = cnt_next + 8'd1;
                        if (cnt_next >= lim) begin
                            halt_next = 1'b1;
                        end
                    end
                end
            end
        end

        if (in_reg.in_last) begin
            if (!halt_next && ph_next) begin
                err_next = ST_OPEN_PAIR;
            end
            res.beats[res.n].kind     = KIND_SUMMARY;
            res.beats[res.n].out_char = 8'h00;
            res.beats[res.n].status   = err_next;
            res.beats[res.n].length   = (err_next != ST_OK) ? 8'd0 : cnt_next;
            res.beats[res.n].run_end  = 1'b0;
            res.n     = res.n + 1'b1;
            ph_next   = 1'b0;
            ad_next   = 1'b0;
            cnt_next  = 8'd0;
            halt_next = 1'b0;
            err_next  = ST_OK;
        end

        if (res.n != '0) begin
            res.beats[res.n - 1'b1].run_end = 1'b1;
        end

        if (!fire) begin
            res.n = '0;
        end
    end

    assign push = res;

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            ph_reg     <= 1'b0;
            ad_reg     <= 1'b0;
            cnt_reg    <= 8'd0;
            halt_reg   <= 1'b0;
            err_reg    <= ST_OK;
        end else begin
            if (s_ready) begin
                in_vld_reg <= in_vld_next;
            end
            if (fire) begin
                ph_reg   <= ph_next;
                ad_reg   <= ad_next;
                cnt_reg  <= cnt_next;
                halt_reg <= halt_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

### hdl/hxn_outq.sv
// Result queue: takes up to three results at once, hands out one beat per cycle while m_ready is high.
// Depends on hxn_pkg for the result struct and queue sizing.
module hxn_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  hxn_pkg::hxn_push_t  push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output hxn_pkg::out_beat_t  m_data
);
    import hxn_pkg::*;

    out_beat_t        q_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             pop;

    assign m_valid = (count_reg != '0);
    assign m_data  = q_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Room is judged on the registered count only, so m_ready never reaches s_ready.
    assign room = (count_reg <= QCW'(QDEPTH - PUSH_MAX));

    assign wr_ptr_next = wr_ptr_reg + QAW'(push.n);
    assign rd_ptr_next = rd_ptr_reg + QAW'(pop);
    assign count_next  = count_reg + QCW'(push.n) - QCW'(pop);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PUSH_MAX; i++) begin
            if (PUSH_CW'(i) < push.n) begin
                q_reg[wr_ptr_reg + QAW'(i)] <= push.beats[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/hxn_checker.sv
// Port-level checks on the result channel of the address normalizer, bound to the top.
// Depends on hxn_pkg and hex_address_normalizer_core_macros.svh.
`include "hex_address_normalizer_core_macros.svh"

module hxn_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input hxn_pkg::out_beat_t m_data
);
    import hxn_pkg::*;

    // A summary always closes the run of results of its input beat.
    `HXN_ASSERT_NOW(a_summary_ends_run, aclk, aresetn, m_valid && m_data.kind == KIND_SUMMARY, m_data.run_end, "summary beat without run_end")
    // An error summary reports no length.
    `HXN_ASSERT_NOW(a_error_zero_len, aclk, aresetn, m_valid && m_data.kind == KIND_SUMMARY && m_data.status != ST_OK, m_data.length == 8'd0, "error summary with nonzero length")
    // Character beats carry no status and no length.
    `HXN_ASSERT_NOW(a_char_clean, aclk, aresetn, m_valid && m_data.kind == KIND_CHAR, m_data.status == ST_OK && m_data.length == 8'd0, "character beat with status or length")
    // A stalled result beat holds.
    `HXN_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

endmodule

bind hex_address_normalizer_core hxn_checker u_hxn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### sim/tb.sv
// Self-checking testbench for hex_address_normalizer_core: directed strings, then
// random strings under six register settings, checked beat by beat against a predictor.
// Depends on hdl/hxn_pkg.sv and hdl/hex_address_normalizer_core.sv.
`timescale 1ns / 100ps

module tb;
    import hxn_pkg::*;

    localparam int NUM_DIR        = 24;
    localparam int NUM_SETTINGS   = 6;
    localparam int RAND_PER_PHASE = 56;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       typed;
        status_t    st;
        logic [7:0] len;
    } dir_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    in_beat_t       s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    out_beat_t      m_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    // Side information that travels with the beat on s_data.
    logic           tag_typed = 1'b0;
    status_t        tag_status = ST_OK;
    logic [7:0]     tag_len = '0;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int n_fail = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_closed = 0;
    int n_strings = 0;

    cfg_t       cfg_now;
    out_beat_t  norm_beats[$];
    out_beat_t  step_beats[$];
    in_beat_t   str_chars[$];
    dir_row_t   dir_rows[NUM_DIR];

    // Predictor state for the string in progress.
    logic       hp_half;
    logic       hp_after_delim;
    int         hp_count;
    logic       hp_halted;
    status_t    hp_status;

    hex_address_normalizer_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    function automatic logic hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic delimiter(input logic [7:0] c);
        return c != 8'h00 && (c == cfg_now.delim_a || c == cfg_now.delim_b ||
                              c == cfg_now.delim_c || c == cfg_now.delim_d);
    endfunction

    task automatic emit_char(input logic [7:0] ch, input int lim);
        out_beat_t r;
        r = '0;
        r.kind = KIND_CHAR;
        r.out_char = ch;
        step_beats.push_back(r);
        hp_count++;
        if (hp_count >= lim) hp_halted = 1'b1;
    endtask

    task automatic stop_with(input status_t st);
        hp_status = st;
        hp_halted = 1'b1;
    endtask

    // Works out the beats that one input character causes and queues them.
    task automatic normalize_char(input in_beat_t b);
        logic [7:0] c;
        int lim;
        out_beat_t r;
        c = b.in_char;
        lim = (int'(cfg_now.out_limit) < LENGTH_MAX) ? int'(cfg_now.out_limit) : LENGTH_MAX;
        step_beats.delete();
        if (!hp_halted && hp_count >= lim) hp_halted = 1'b1;
        if (!hp_halted) begin
            if (c == 8'h00) begin
                if (hp_half) hp_status = ST_OPEN_PAIR;
                hp_halted = 1'b1;
            end else if (hp_half) begin
                if (!hex_digit(c)) begin
                    stop_with(ST_BAD_DIGIT);
                end else begin
                    hp_half = 1'b0;
                    hp_after_delim = 1'b0;
                    emit_char(c, lim);
                end
            end else if (blank(c)) begin
                // whitespace between pairs is dropped
            end else if (delimiter(c)) begin
                if (hp_after_delim) stop_with(ST_DOUBLE_DELIM);
                else hp_after_delim = 1'b1;
            end else begin
                if (hp_count > 0 && cfg_now.out_separator != 8'h00)
                    emit_char(cfg_now.out_separator, lim);
                if (!hp_halted) begin
                    if (!hex_digit(c)) begin
                        stop_with(ST_BAD_DIGIT);
                    end else begin
                        hp_half = 1'b1;
                        emit_char(c, lim);
                    end
                end
            end
        end
        if (b.in_last) begin
            if (!hp_halted && hp_half) stop_with(ST_OPEN_PAIR);
            r = '0;
            r.kind = KIND_SUMMARY;
            r.status = hp_status;
            r.length = (hp_status != ST_OK) ? 8'd0 : 8'(hp_count);
            step_beats.push_back(r);
            hp_half = 1'b0;
            hp_after_delim = 1'b0;
            hp_count = 0;
            hp_halted = 1'b0;
            hp_status = ST_OK;
        end
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].run_end = 1'b1;
        foreach (step_beats[i]) norm_beats.push_back(step_beats[i]);
    endtask

    task automatic compare_beat(input out_beat_t got);
        out_beat_t want;
        if (norm_beats.size() == 0) begin
            $error("result beat with nothing outstanding: %h", got);
            n_fail++;
            return;
        end
        want = norm_beats.pop_front();
        n_checked++;
        if (want.kind == KIND_SUMMARY) n_closed++;
        if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            n_fail++;
        end
        if (got.out_char !== want.out_char) begin
            $error("out_char: expected 0x%h, got 0x%h", want.out_char, got.out_char);
            n_fail++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_fail++;
        end
        if (got.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, got.length);
            n_fail++;
        end
        if (got.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            n_fail++;
        end
    endtask

    // Results are checked before the beat accepted at the same edge is predicted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) compare_beat(m_data);
            if (s_valid && s_ready) begin
                normalize_char(s_data);
                n_sent++;
                if (tag_typed)
                    norm_beats[norm_beats.size() - 1] =
                        '{kind: KIND_SUMMARY, out_char: 8'h00, status: tag_status,
                          length: tag_len, run_end: 1'b1};
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
            default: begin src_idle_pct = 11; snk_stall_pct = 11; end
        endcase
    endtask

    task automatic put_char(input in_beat_t b, input logic typed, input status_t st,
                            input logic [7:0] len);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        tag_typed <= typed;
        tag_status <= st;
        tag_len <= len;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lets every outstanding beat drain, plus the latency of beats that cause nothing.
    // The first edge makes sure the last accepted beat has been predicted.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (norm_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= {24'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DELIM_A: cfg_now.delim_a = v;
            REG_DELIM_B: cfg_now.delim_b = v;
            REG_DELIM_C: cfg_now.delim_c = v;
            REG_DELIM_D: cfg_now.delim_d = v;
            REG_OUT_SEP: cfg_now.out_separator = v;
            default:     cfg_now.out_limit = v;
        endcase
    endtask

    // Settings cover hex and whitespace delimiters, disabled slots, no separator,
    // a zero limit and limits that cut a pair in half.
    function automatic cfg_t setting_for(input int k);
        case (k)
            1: return '{8'h3A, 8'h2D, 8'h2E, 8'h20, 8'h2D, 8'hFF};
            2: return '{8'h61, 8'h3A, 8'h00, 8'h09, 8'h00, 8'hFE};
            3: return '{8'hFF, 8'h80, 8'h5F, 8'h00, 8'hFF, 8'h07};
            4: return '{8'h00, 8'h00, 8'h00, 8'h00, 8'h2E, 8'h00};
            default: return '{8'h2C, 8'h3A, 8'h2D, 8'h2F, 8'h3A, 8'h01};
        endcase
    endfunction

    task automatic apply_setting(input cfg_t c);
        wait_quiet();
        reg_write(REG_DELIM_A, c.delim_a);
        reg_write(REG_DELIM_B, c.delim_b);
        reg_write(REG_DELIM_C, c.delim_c);
        reg_write(REG_DELIM_D, c.delim_d);
        reg_write(REG_OUT_SEP, c.out_separator);
        reg_write(REG_OUT_LIM, c.out_limit);
    endtask

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(21)];
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    // Returns one of the enabled delimiters, or zero when all slots are off.
    function automatic logic [7:0] pick_delim();
        logic [7:0] pool[$];
        if (cfg_now.delim_a != 8'h00) pool.push_back(cfg_now.delim_a);
        if (cfg_now.delim_b != 8'h00) pool.push_back(cfg_now.delim_b);
        if (cfg_now.delim_c != 8'h00) pool.push_back(cfg_now.delim_c);
        if (cfg_now.delim_d != 8'h00) pool.push_back(cfg_now.delim_d);
        if (pool.size() == 0) return 8'h00;
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic add_char(input logic [7:0] c);
        str_chars.push_back('{in_char: c, in_last: 1'b0});
    endtask

    // Mostly well-formed addresses with random digits; some get one defect, the
    // rest are random mixes of bytes, hex digits, whitespace and delimiters.
    task automatic build_string();
        int style, pairs, cut, tail;
        logic [7:0] d;
        str_chars.delete();
        style = $urandom_range(99);
        if (style < 85) begin
            pairs = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
            if ($urandom_range(3) == 0) add_char(pick_blank());
            for (int p = 0; p < pairs; p++) begin
                if (p > 0 && $urandom_range(4) != 0) begin
                    if ($urandom_range(3) == 0) add_char(pick_blank());
                    d = pick_delim();
                    if (d != 8'h00 && $urandom_range(9) < 7) add_char(d);
                    if ($urandom_range(3) == 0) add_char(pick_blank());
                end
                add_char(pick_hex());
                add_char(pick_hex());
            end
            if (style >= 70) begin
                cut = $urandom_range(str_chars.size() - 1);
                case ($urandom_range(2))
                    0: if (str_chars.size() > 1) str_chars.delete(cut);
                    1: str_chars[cut].in_char = 8'($urandom_range(255));
                    default: begin
                        d = pick_delim();
                        if (d == 8'h00) d = 8'($urandom_range(255));
                        add_char(d);
                        if ($urandom_range(1) == 0) add_char(pick_blank());
                        add_char(pick_delim() == 8'h00 ? d : pick_delim());
                        add_char(pick_hex());
                        add_char(pick_hex());
                    end
                endcase
            end
            tail = $urandom_range(99);
            if (tail >= 60) add_char(8'h00);
            if (tail >= 85) begin
                repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(255)));
            end
        end else begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(3))
                    0: add_char(8'($urandom_range(255)));
                    1: add_char(pick_hex());
                    2: add_char(pick_blank());
                    default: begin
                        d = pick_delim();
                        add_char(d == 8'h00 ? 8'($urandom_range(128, 255)) : d);
                    end
                endcase
            end
        end
        str_chars[str_chars.size() - 1].in_last = 1'b1;
    endtask

    initial begin
        int phase_start;
        cfg_now = '{8'd58, 8'd45, 8'd0, 8'd0, 8'd58, 8'd255};
        hp_half = 1'b0;
        hp_after_delim = 1'b0;
        hp_count = 0;
        hp_halted = 1'b0;
        hp_status = ST_OK;

        // Typed summaries are the ones that are obvious: empty string and errors.
        dir_rows = '{
            '{8'h00, 1'b1, 1'b1, ST_OK,           8'd0},
            '{8'h20, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h30, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h46, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h3A, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h61, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h39, 1'b1, 1'b0, ST_OK,           8'd0},
            '{8'h3A, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h2D, 1'b1, 1'b1, ST_DOUBLE_DELIM, 8'd0},
            '{8'h66, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h67, 1'b1, 1'b1, ST_BAD_DIGIT,    8'd0},
            '{8'h37, 1'b1, 1'b1, ST_OPEN_PAIR,    8'd0},
            '{8'h63, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h00, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'hFF, 1'b1, 1'b1, ST_OPEN_PAIR,    8'd0},
            '{8'h64, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h45, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h00, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h7A, 1'b1, 1'b0, ST_OK,           8'd0},
            '{8'h47, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h80, 1'b1, 1'b1, ST_BAD_DIGIT,    8'd0},
            '{8'h0D, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h42, 1'b0, 1'b0, ST_OK,           8'd0},
            '{8'h0B, 1'b1, 1'b1, ST_BAD_DIGIT,    8'd0}
        };

        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIR; i++) begin
            set_idling((i / 6) % 4);
            put_char('{in_char: dir_rows[i].chr, in_last: dir_rows[i].last},
                     dir_rows[i].typed, dir_rows[i].st, dir_rows[i].len);
        end

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            if (k > 0) apply_setting(setting_for(k));
            phase_start = n_sent;
            while (n_sent - phase_start < RAND_PER_PHASE) begin
                set_idling((n_strings / 3) % 4);
                build_string();
                foreach (str_chars[i]) put_char(str_chars[i], 1'b0, ST_OK, 8'd0);
                n_strings++;
            end
        end

        wait_quiet();
        $display("tb: %0d characters in %0d strings, %0d result beats compared",
                 n_sent, n_strings + 9, n_checked);
        $display("tb: %0d summaries checked over %0d register settings",
                 n_closed, NUM_SETTINGS);
        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/hxn_pkg.sv
hdl/hxn_regs.sv
hdl/hxn_parser.sv
hdl/hxn_outq.sv
hdl/hex_address_normalizer_core.sv
hdl/hxn_checker.sv
sim/tb.sv
